@@ rtl/core/hrp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared widths, character codes and lookup functions for the HTTP
// request header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrp_pkg;

  localparam int unsigned MaxBufferDefault = 65536;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned MethW  = 4;
  localparam int unsigned OffW   = 16;
  localparam int unsigned VerW   = 8;
  localparam int unsigned CountW = 16;

  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  // Request-line token phases.
  localparam logic [2:0] TpLead    = 3'd0;
  localparam logic [2:0] TpMethod  = 3'd1;
  localparam logic [2:0] TpSpace1  = 3'd2;
  localparam logic [2:0] TpUri     = 3'd3;
  localparam logic [2:0] TpSpace2  = 3'd4;
  localparam logic [2:0] TpVersion = 3'd5;
  localparam logic [2:0] TpAfter   = 3'd6;
  localparam logic [2:0] TpStopped = 3'd7;

  // Version token phases; codes below VpSignMaj walk the "HTTP/" prefix.
  localparam logic [3:0] VpPrefix  = 4'd0;
  localparam logic [3:0] VpSignMaj = 4'd5;
  localparam logic [3:0] VpDigMaj  = 4'd6;
  localparam logic [3:0] VpMajor   = 4'd7;
  localparam logic [3:0] VpSignMin = 4'd8;
  localparam logic [3:0] VpDigMin  = 4'd9;
  localparam logic [3:0] VpMinor   = 4'd10;
  localparam logic [3:0] VpDone    = 4'd11;
  localparam logic [3:0] VpBad     = 4'd15;

  localparam int unsigned NumMethods = 8;

  // Method names, left-justified: character k sits in bits 63-8k down.
  localparam logic [63:0] MethodName [NumMethods] = '{
    {"OPTIONS", 8'h00},
    {"GET", 40'h0},
    {"HEAD", 32'h0},
    {"POST", 32'h0},
    {"PUT", 40'h0},
    {"DELETE", 16'h0},
    {"TRACE", 24'h0},
    {"CONNECT", 8'h00}
  };

  localparam logic [3:0] MethodLen [NumMethods] = '{
    4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
  };

  localparam logic [39:0] VersionPrefix = "HTTP/";

  function automatic logic [ByteW-1:0] method_char(input logic [2:0] j, input logic [2:0] k);
    logic [63:0] name;
    name = MethodName[j];
    return name[63 - 8*k -: 8];
  endfunction

  function automatic logic [ByteW-1:0] prefix_char(input logic [2:0] k);
    return VersionPrefix[39 - 8*k -: 8];
  endfunction

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Decimal accumulate with saturation at 255; a negative number reads as 0.
  function automatic logic [VerW-1:0] acc_digit(input logic [VerW-1:0] acc,
                                                input logic [ByteW-1:0] c,
                                                input logic neg);
    logic [11:0] v;
    v = 12'(acc) * 12'd10 + 12'(c - ChZero);
    if (neg) begin
      return '0;
    end
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hrp_if.sv @@
// ----------------------------------------------------------------------------
// hrp_in_if / hrp_out_if
// Valid/ready channels for the request bytes and the per-buffer summary.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrp_in_if;
  logic                        valid;
  logic                        ready;
  logic [hrp_pkg::ByteW-1:0]   data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [hrp_pkg::MethW-1:0]   method_code;
  logic [hrp_pkg::OffW-1:0]    uri_offset;
  logic [hrp_pkg::OffW-1:0]    uri_length;
  logic [hrp_pkg::VerW-1:0]    version_major;
  logic [hrp_pkg::VerW-1:0]    version_minor;
  logic [hrp_pkg::OffW-1:0]    body_start;
  logic [hrp_pkg::CountW-1:0]  field_count;

  modport source (output valid, output status, output method_code, output uri_offset,
                  output uri_length, output version_major, output version_minor,
                  output body_start, output field_count, input ready);
  modport sink (input valid, input status, input method_code, input uri_offset,
                input uri_length, input version_major, input version_minor,
                input body_start, input field_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/http_request_header_parser.sv @@
// ----------------------------------------------------------------------------
// http_request_header_parser
// Streams a request buffer byte by byte and returns one header summary on the
// byte flagged last: method, URI span, version, header end and line count.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while no last byte stalls. An
// accepted last byte waits in the input register while the combinational
// parse step updates the running state (last three bytes, offset, token and
// version phases, method match mask) and loads the result register. The
// result sits in an output register, so bytes of the next buffer keep
// flowing while a summary waits; only a second last byte stalls until the
// previous summary is taken. Bytes at offsets of MAX_BUFFER or more are
// ignored apart from their last flag. There are no configuration registers
// and no start-up sweep.
`default_nettype none

module http_request_header_parser #(
  parameter int unsigned MAX_BUFFER = hrp_pkg::MaxBufferDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  hrp_in_if.sink     in_i,
  hrp_out_if.source  out_o
);

  localparam int unsigned PosW = $clog2(MAX_BUFFER + 1);
  localparam int unsigned ExtW = PosW + hrp_pkg::OffW;

  // Input register.
  logic                       in_valid_q;
  logic [hrp_pkg::ByteW-1:0]  in_byte_q;
  logic                       in_last_q;

  // Parse state.
  logic [23:0]                recent_q, recent_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic                       fld_q, fld_d;
  logic                       hd_q, hd_d;
  logic [hrp_pkg::CountW-1:0] lines_q, lines_d;
  logic [2:0]                 tp_q, tp_d;
  logic [7:0]                 mask_q, mask_d;
  logic [3:0]                 mci_q, mci_d;
  logic [PosW-1:0]            uri_start_q, uri_start_d;
  logic [hrp_pkg::OffW-1:0]   uri_count_q, uri_count_d;
  logic [3:0]                 vp_q, vp_d;
  logic [hrp_pkg::VerW-1:0]   major_q, major_d;
  logic [hrp_pkg::VerW-1:0]   minor_q, minor_d;
  logic [PosW-1:0]            end_q, end_d;
  logic                       neg_q, neg_d;

  // Output register.
  logic                       out_valid_q;
  logic                       res_status_q, res_status_d;
  logic [hrp_pkg::MethW-1:0]  res_method_q, res_method_d;
  logic [hrp_pkg::OffW-1:0]   res_uri_off_q, res_uri_off_d;
  logic [hrp_pkg::OffW-1:0]   res_uri_len_q, res_uri_len_d;
  logic [hrp_pkg::VerW-1:0]   res_major_q, res_major_d;
  logic [hrp_pkg::VerW-1:0]   res_minor_q, res_minor_d;
  logic [hrp_pkg::OffW-1:0]   res_body_q, res_body_d;
  logic [hrp_pkg::CountW-1:0] res_fields_q, res_fields_d;

  logic advance;
  logic load_result;

  // A byte that produces no summary never waits on the output side.
  assign advance     = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign load_result = advance && in_last_q;
  assign in_i.ready  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // Parse step for the byte in the input register.
  always_comb begin
    logic [hrp_pkg::ByteW-1:0] c;
    logic                      line_end;
    logic                      sp;
    logic                      do_method;
    logic                      do_version;
    logic                      ver_ok;
    logic [hrp_pkg::MethW-1:0] code;
    logic [ExtW-1:0]           ext;

    c           = in_byte_q;
    ext         = '0;
    recent_d    = recent_q;
    pos_d       = pos_q;
    fld_d       = fld_q;
    hd_d        = hd_q;
    lines_d     = lines_q;
    tp_d        = tp_q;
    mask_d      = mask_q;
    mci_d       = mci_q;
    uri_start_d = uri_start_q;
    uri_count_d = uri_count_q;
    vp_d        = vp_q;
    major_d     = major_q;
    minor_d     = minor_q;
    end_d       = end_q;
    neg_d       = neg_q;
    do_method   = 1'b0;
    do_version  = 1'b0;
    sp          = hrp_pkg::is_space(c);
    line_end    = (c == hrp_pkg::ChLf) && (recent_q[7:0] == hrp_pkg::ChCr) && (pos_q != '0);

    if (pos_q < PosW'(MAX_BUFFER)) begin
      if (!hd_q) begin
        if (!fld_q) begin
          if (line_end) begin
            fld_d = 1'b1;
          end else if (tp_q < hrp_pkg::TpAfter) begin
            if (c == hrp_pkg::ChNul) begin
              tp_d = hrp_pkg::TpStopped;
            end else begin
              case (tp_q)
                hrp_pkg::TpLead: begin
                  if (!sp) begin
                    tp_d      = hrp_pkg::TpMethod;
                    do_method = 1'b1;
                  end
                end
                hrp_pkg::TpMethod: begin
                  if (sp) tp_d = hrp_pkg::TpSpace1;
                  else do_method = 1'b1;
                end
                hrp_pkg::TpSpace1: begin
                  if (!sp) begin
                    tp_d        = hrp_pkg::TpUri;
                    uri_start_d = pos_q;
                    uri_count_d = 16'd1;
                  end
                end
                hrp_pkg::TpUri: begin
                  if (sp) tp_d = hrp_pkg::TpSpace2;
                  else if (uri_count_q != 16'hFFFF) uri_count_d = uri_count_q + 16'd1;
                end
                hrp_pkg::TpSpace2: begin
                  if (!sp) begin
                    tp_d       = hrp_pkg::TpVersion;
                    do_version = 1'b1;
                  end
                end
                default: begin
                  if (sp) tp_d = hrp_pkg::TpAfter;
                  else do_version = 1'b1;
                end
              endcase
            end
          end
        end

        if (do_method) begin
          for (int j = 0; j < hrp_pkg::NumMethods; j++) begin
            if (mci_q >= hrp_pkg::MethodLen[j] ||
                hrp_pkg::method_char(3'(j), mci_q[2:0]) != c) begin
              mask_d[j] = 1'b0;
            end
          end
          if (mci_q < 4'd8) mci_d = mci_q + 4'd1;
        end

        if (do_version) begin
          if (vp_q < hrp_pkg::VpSignMaj) begin
            if (c == hrp_pkg::prefix_char(vp_q[2:0])) vp_d = vp_q + 4'd1;
            else vp_d = hrp_pkg::VpBad;
          end else if ((vp_q == hrp_pkg::VpSignMaj || vp_q == hrp_pkg::VpSignMin) &&
                       (c == hrp_pkg::ChPlus || c == hrp_pkg::ChMinus)) begin
            neg_d = (c == hrp_pkg::ChMinus);
            vp_d  = vp_q + 4'd1;
          end else if (vp_q == hrp_pkg::VpSignMaj || vp_q == hrp_pkg::VpDigMaj ||
                       vp_q == hrp_pkg::VpSignMin || vp_q == hrp_pkg::VpDigMin) begin
            if (!hrp_pkg::is_digit(c)) begin
              vp_d = hrp_pkg::VpBad;
            end else if (vp_q <= hrp_pkg::VpDigMaj) begin
              major_d = hrp_pkg::acc_digit(major_q, c, neg_q);
              vp_d    = hrp_pkg::VpMajor;
            end else begin
              minor_d = hrp_pkg::acc_digit(minor_q, c, neg_q);
              vp_d    = hrp_pkg::VpMinor;
            end
          end else if (vp_q == hrp_pkg::VpMajor) begin
            if (hrp_pkg::is_digit(c)) begin
              major_d = hrp_pkg::acc_digit(major_q, c, neg_q);
            end else if (c == hrp_pkg::ChDot) begin
              neg_d = 1'b0;
              vp_d  = hrp_pkg::VpSignMin;
            end else begin
              vp_d = hrp_pkg::VpBad;
            end
          end else if (vp_q == hrp_pkg::VpMinor) begin
            if (hrp_pkg::is_digit(c)) minor_d = hrp_pkg::acc_digit(minor_q, c, neg_q);
            else vp_d = hrp_pkg::VpDone;
          end
        end

        if (line_end) begin
          if (lines_q != 16'hFFFF) lines_d = lines_q + 16'd1;
          // Blank line: the previous two bytes were CR LF as well.
          if (pos_q > PosW'(4) && recent_q[15:8] == hrp_pkg::ChLf &&
              recent_q[23:16] == hrp_pkg::ChCr) begin
            end_d = pos_q + PosW'(1);
            hd_d  = 1'b1;
          end
        end
        recent_d = {recent_q[15:0], c};
      end
      pos_d = pos_q + PosW'(1);
    end

    // Summary from the updated state.
    code = '0;
    for (int j = 0; j < hrp_pkg::NumMethods; j++) begin
      if (mask_d[j] && hrp_pkg::MethodLen[j] == mci_d) code = 4'(j + 1);
    end
    ver_ok = (vp_d == hrp_pkg::VpMinor) || (vp_d == hrp_pkg::VpDone);

    res_status_d  = 1'b1;
    res_method_d  = '0;
    res_uri_off_d = '0;
    res_uri_len_d = '0;
    res_major_d   = '0;
    res_minor_d   = '0;
    res_body_d    = '0;
    res_fields_d  = '0;
    if (fld_d) begin
      res_status_d  = 1'b0;
      res_method_d  = code;
      ext           = ExtW'(uri_start_d);
      if (uri_count_d != '0) begin
        res_uri_off_d = (ext > ExtW'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
      end
      res_uri_len_d = uri_count_d;
      res_major_d   = ver_ok ? major_d : 8'd1;
      res_minor_d   = ver_ok ? minor_d : 8'd1;
      ext           = ExtW'(end_d);
      if (hd_d) begin
        res_body_d = (ext > ExtW'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
        if (lines_d >= 16'd2) res_fields_d = lines_d - 16'd2;
      end
    end

    // The last byte of a buffer returns the parser to its reset state.
    if (in_last_q) begin
      recent_d    = '0;
      pos_d       = '0;
      fld_d       = 1'b0;
      hd_d        = 1'b0;
      lines_d     = '0;
      tp_d        = hrp_pkg::TpLead;
      mask_d      = '1;
      mci_d       = '0;
      uri_start_d = '0;
      uri_count_d = '0;
      vp_d        = hrp_pkg::VpPrefix;
      major_d     = '0;
      minor_d     = '0;
      end_d       = '0;
      neg_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q    <= '0;
      pos_q       <= '0;
      fld_q       <= 1'b0;
      hd_q        <= 1'b0;
      lines_q     <= '0;
      tp_q        <= hrp_pkg::TpLead;
      mask_q      <= '1;
      mci_q       <= '0;
      uri_start_q <= '0;
      uri_count_q <= '0;
      vp_q        <= hrp_pkg::VpPrefix;
      major_q     <= '0;
      minor_q     <= '0;
      end_q       <= '0;
      neg_q       <= 1'b0;
    end else if (advance) begin
      recent_q    <= recent_d;
      pos_q       <= pos_d;
      fld_q       <= fld_d;
      hd_q        <= hd_d;
      lines_q     <= lines_d;
      tp_q        <= tp_d;
      mask_q      <= mask_d;
      mci_q       <= mci_d;
      uri_start_q <= uri_start_d;
      uri_count_q <= uri_count_d;
      vp_q        <= vp_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      end_q       <= end_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      res_status_q  <= res_status_d;
      res_method_q  <= res_method_d;
      res_uri_off_q <= res_uri_off_d;
      res_uri_len_q <= res_uri_len_d;
      res_major_q   <= res_major_d;
      res_minor_q   <= res_minor_d;
      res_body_q    <= res_body_d;
      res_fields_q  <= res_fields_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = res_status_q;
  assign out_o.method_code   = res_method_q;
  assign out_o.uri_offset    = res_uri_off_q;
  assign out_o.uri_length    = res_uri_len_q;
  assign out_o.version_major = res_major_q;
  assign out_o.version_minor = res_minor_q;
  assign out_o.body_start    = res_body_q;
  assign out_o.field_count   = res_fields_q;

endmodule

`default_nettype wire
